// File: hdl/hct_pkg.sv
// Shared types and constants for the heightmap cell tessellator.
// Used by hct_normal_pipe and heightmap_cell_tessellator; depends on nothing.
package hct_pkg;

   localparam int CELL_W   = 12;
   localparam int HGT_W    = 8;
   localparam int SCALE_W  = 24;
   localparam int GRID_W   = 13;
   localparam int COLOR_W  = 24;
   localparam int POS_W    = 32;
   localparam int NRM_W    = 16;
   localparam int CSR_IDX_W = 3;

   localparam int PROD_W   = 56;
   localparam int MAG_W    = 30;
   localparam int SUM_W    = 62;
   localparam int ROOT_W   = 63;
   localparam int LEN_W    = 31;
   localparam int SQ_STEPS = 31;
   localparam int SHIFT_W  = 5;

   // Registers ahead of the divider, plus its load stage and the output stage.
   localparam int NRM_BASE_LAT = 7 + SQ_STEPS + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Z      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_STEP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_ENABLE = 3'd4;

   localparam logic [1:0] HSEL_00 = 2'd0;
   localparam logic [1:0] HSEL_01 = 2'd1;
   localparam logic [1:0] HSEL_11 = 2'd2;
   localparam logic [1:0] HSEL_10 = 2'd3;

   typedef struct packed {
      logic             valid;
      logic             second;
      logic             a_neg;
      logic [HGT_W-1:0] a_mag;
      logic             c_neg;
      logic [HGT_W-1:0] c_mag;
   } job_type;

   typedef struct packed {
      logic                  valid;
      logic                  second;
      logic [2:0][NRM_W-1:0] nrm;
   } nrm_out_type;

   typedef struct packed {
      logic             dx;
      logic             dz;
      logic [1:0]       hsel;
   } corner_type;

   function automatic corner_type vertex_corner(input logic [2:0] k);
      corner_type c;
      c = '{dx: 1'b0, dz: 1'b0, hsel: HSEL_00};
      case (k)
         3'd1: c = '{dx: 1'b0, dz: 1'b1, hsel: HSEL_01};
         3'd2: c = '{dx: 1'b1, dz: 1'b1, hsel: HSEL_11};
         3'd3: c = '{dx: 1'b1, dz: 1'b1, hsel: HSEL_11};
         3'd4: c = '{dx: 1'b1, dz: 1'b0, hsel: HSEL_10};
         default: c = '{dx: 1'b0, dz: 1'b0, hsel: HSEL_00};
      endcase
      return c;
   endfunction

endpackage

// File: hdl/hct_normal_pipe.sv
// Pipelined unit face normal of one triangle per job: cross product, scaling,
// square root and division, one register stage per root or quotient step. Uses hct_pkg.
module hct_normal_pipe #(
   parameter int FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hct_pkg::job_type              job,
   input  logic [hct_pkg::SCALE_W-1:0]   scale_x,
   input  logic [hct_pkg::SCALE_W-1:0]   scale_z,
   input  logic [hct_pkg::SCALE_W-1:0]   height_step,
   output hct_pkg::nrm_out_type          nout
);
   import hct_pkg::*;

   localparam int QW = FRAC_BITS + 1;
   localparam int DW = MAG_W + FRAC_BITS + 1;

   typedef struct packed {
      logic       valid;
      logic       second;
      logic       zero;
      logic [2:0] neg;
   } ctl_type;

   ctl_type                 s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff, s6_ctl_ff;
   logic [31:0]             s1_p0_ff, s1_p2_ff;
   logic [47:0]             s1_p1_ff;
   logic [2:0][PROD_W-1:0]  s2_m_ff, s3_m_ff, s4_m_ff;
   logic [PROD_W-1:0]       s3_max_ff;
   logic [SHIFT_W-1:0]      s4_k_ff;
   logic [2:0][MAG_W-1:0]   s5_mag_ff, s6_mag_ff;
   logic [2:0][2*MAG_W-1:0] s6_sq_ff;

   ctl_type                 sq_ctl_ff [0:SQ_STEPS];
   logic [ROOT_W-1:0]       sq_x_ff   [0:SQ_STEPS];
   logic [ROOT_W-1:0]       sq_r_ff   [0:SQ_STEPS];
   logic [2:0][MAG_W-1:0]   sq_mag_ff [0:SQ_STEPS];
   logic [ROOT_W-1:0]       sq_x_in   [0:SQ_STEPS-1];
   logic [ROOT_W-1:0]       sq_r_in   [0:SQ_STEPS-1];

   ctl_type                 dv_ctl_ff [0:QW];
   logic [LEN_W-1:0]        dv_len_ff [0:QW];
   logic [2:0][DW-1:0]      dv_rem_ff [0:QW];
   logic [2:0][QW-1:0]      dv_q_ff   [0:QW];
   logic [2:0][DW-1:0]      dv_rem_in [0:QW-1];
   logic [2:0][QW-1:0]      dv_q_in   [0:QW-1];

   logic [PROD_W-1:0]       max01;
   logic [5:0]              bitlen;
   logic [SHIFT_W-1:0]      k_in;
   logic [SUM_W-1:0]        sum_in;
   logic [LEN_W-1:0]        len_end;
   logic [2:0][DW-1:0]      rem0_in;
   logic [2:0][NRM_W-1:0]   nrm_in;
   nrm_out_type             nout_ff;

   assign max01 = (s2_m_ff[0] > s2_m_ff[1]) ? s2_m_ff[0] : s2_m_ff[1];

   always_comb begin
      bitlen = '0;
      for (int i = 0; i < PROD_W; i++) begin
         if (s3_max_ff[i]) begin
            bitlen = 6'(i + 1);
         end
      end
      k_in = (bitlen > 6'(MAG_W)) ? SHIFT_W'(bitlen - 6'(MAG_W)) : '0;
   end

   assign sum_in = SUM_W'(s6_sq_ff[0]) + SUM_W'(s6_sq_ff[1]) + SUM_W'(s6_sq_ff[2]);

   always_comb begin
      for (int i = 0; i < SQ_STEPS; i++) begin
         logic [ROOT_W-1:0] bitv;
         logic [ROOT_W-1:0] t;
         bitv = ROOT_W'(1) << (2 * (SQ_STEPS - 1 - i));
         t    = sq_r_ff[i] + bitv;
         if (sq_x_ff[i] >= t) begin
            sq_x_in[i] = sq_x_ff[i] - t;
            sq_r_in[i] = (sq_r_ff[i] >> 1) + bitv;
         end else begin
            sq_x_in[i] = sq_x_ff[i];
            sq_r_in[i] = sq_r_ff[i] >> 1;
         end
      end
   end

   assign len_end = sq_r_ff[SQ_STEPS][LEN_W-1:0];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rem0_in[c] = (DW'(sq_mag_ff[SQ_STEPS][c]) << FRAC_BITS) + DW'(len_end >> 1);
      end
   end

   always_comb begin
      for (int j = 0; j < QW; j++) begin
         for (int c = 0; c < 3; c++) begin
            logic [DW-1:0] den;
            den = DW'(dv_len_ff[j]) << (QW - 1 - j);
            dv_q_in[j][c] = dv_q_ff[j][c];
            if (dv_rem_ff[j][c] >= den) begin
               dv_rem_in[j][c] = dv_rem_ff[j][c] - den;
               dv_q_in[j][c][QW-1-j] = 1'b1;
            end else begin
               dv_rem_in[j][c] = dv_rem_ff[j][c];
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [QW+NRM_W-1:0] qx;
         logic [NRM_W-1:0]    q16;
         qx  = {{NRM_W{1'b0}}, dv_q_ff[QW][c]};
         q16 = qx[NRM_W-1:0];
         if (dv_ctl_ff[QW].zero) begin
            nrm_in[c] = '0;
         end else if (dv_ctl_ff[QW].neg[c]) begin
            nrm_in[c] = NRM_W'(0) - q16;
         end else begin
            nrm_in[c] = q16;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff <= '{valid: job.valid, second: job.second, zero: 1'b0,
                     neg: {job.c_neg, 1'b0, job.a_neg}};
      s1_p0_ff  <= 32'(job.a_mag) * 32'(height_step);
      s1_p1_ff  <= 48'(scale_x) * 48'(scale_z);
      s1_p2_ff  <= 32'(job.c_mag) * 32'(height_step);

      s2_ctl_ff  <= s1_ctl_ff;
      s2_m_ff[0] <= PROD_W'(s1_p0_ff) * PROD_W'(scale_z);
      s2_m_ff[1] <= PROD_W'(s1_p1_ff);
      s2_m_ff[2] <= PROD_W'(s1_p2_ff) * PROD_W'(scale_x);

      s3_ctl_ff <= s2_ctl_ff;
      s3_m_ff   <= s2_m_ff;
      s3_max_ff <= (max01 > s2_m_ff[2]) ? max01 : s2_m_ff[2];

      s4_ctl_ff <= s3_ctl_ff;
      s4_m_ff   <= s3_m_ff;
      s4_k_ff   <= k_in;

      s5_ctl_ff <= s4_ctl_ff;
      for (int c = 0; c < 3; c++) begin
         s5_mag_ff[c] <= MAG_W'(s4_m_ff[c] >> s4_k_ff);
      end

      s6_ctl_ff <= s5_ctl_ff;
      s6_mag_ff <= s5_mag_ff;
      for (int c = 0; c < 3; c++) begin
         s6_sq_ff[c] <= (2*MAG_W)'(s5_mag_ff[c]) * (2*MAG_W)'(s5_mag_ff[c]);
      end

      sq_ctl_ff[0] <= '{valid: s6_ctl_ff.valid, second: s6_ctl_ff.second,
                        zero: (sum_in == '0), neg: s6_ctl_ff.neg};
      sq_x_ff[0]   <= ROOT_W'(sum_in);
      sq_r_ff[0]   <= '0;
      sq_mag_ff[0] <= s6_mag_ff;
      for (int i = 0; i < SQ_STEPS; i++) begin
         sq_ctl_ff[i+1] <= sq_ctl_ff[i];
         sq_x_ff[i+1]   <= sq_x_in[i];
         sq_r_ff[i+1]   <= sq_r_in[i];
         sq_mag_ff[i+1] <= sq_mag_ff[i];
      end

      dv_ctl_ff[0] <= sq_ctl_ff[SQ_STEPS];
      dv_len_ff[0] <= len_end;
      dv_rem_ff[0] <= rem0_in;
      dv_q_ff[0]   <= '0;
      for (int j = 0; j < QW; j++) begin
         dv_ctl_ff[j+1] <= dv_ctl_ff[j];
         dv_len_ff[j+1] <= dv_len_ff[j];
         dv_rem_ff[j+1] <= dv_rem_in[j];
         dv_q_ff[j+1]   <= dv_q_in[j];
      end

      nout_ff.valid  <= dv_ctl_ff[QW].valid;
      nout_ff.second <= dv_ctl_ff[QW].second;
      nout_ff.nrm    <= nrm_in;

      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
         s3_ctl_ff.valid <= 1'b0;
         s4_ctl_ff.valid <= 1'b0;
         s5_ctl_ff.valid <= 1'b0;
         s6_ctl_ff.valid <= 1'b0;
         for (int i = 0; i <= SQ_STEPS; i++) begin
            sq_ctl_ff[i].valid <= 1'b0;
         end
         for (int j = 0; j <= QW; j++) begin
            dv_ctl_ff[j].valid <= 1'b0;
         end
         nout_ff.valid <= 1'b0;
      end
   end

   assign nout = nout_ff;

endmodule

// File: hdl/heightmap_cell_tessellator.sv
// Top level of the heightmap cell tessellator: command input, register port,
// the normal pipeline and the six-word vertex emitter. Uses hct_pkg, hct_normal_pipe.
//
//   channel   ports            handshake
//   input     req_*            start high while busy low
//   result    rsp_*            rsp_valid per word, no back-pressure
//   register  csr_*            csr_valid and csr_ready (always ready)
//
// A new cell is taken only once busy drops, which spaces cells by the length of
// their six-word burst on the result port. The delay from start to the first
// word is set by the depth of the normal pipeline (square root and divider).
// Reset clears the pipeline valid bits and the registers to their defaults.
// Nothing on the result side stalls the block.
module heightmap_cell_tessellator #(
   parameter int MAX_GRID         = 4096,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [hct_pkg::CELL_W-1:0]          req_cell_x,
   input  logic [hct_pkg::CELL_W-1:0]          req_cell_z,
   input  logic [hct_pkg::HGT_W-1:0]           req_height_00,
   input  logic [hct_pkg::HGT_W-1:0]           req_height_01,
   input  logic [hct_pkg::HGT_W-1:0]           req_height_11,
   input  logic [hct_pkg::HGT_W-1:0]           req_height_10,
   input  logic [hct_pkg::COLOR_W-1:0]         req_color_first,
   input  logic [hct_pkg::COLOR_W-1:0]         req_color_second,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hct_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hct_pkg::SCALE_W-1:0]         csr_data,
   output logic                                rsp_valid,
   output logic signed [hct_pkg::POS_W-1:0]    rsp_pos_x,
   output logic [hct_pkg::POS_W-1:0]           rsp_pos_y,
   output logic signed [hct_pkg::POS_W-1:0]    rsp_pos_z,
   output logic signed [hct_pkg::NRM_W-1:0]    rsp_normal_x,
   output logic signed [hct_pkg::NRM_W-1:0]    rsp_normal_y,
   output logic signed [hct_pkg::NRM_W-1:0]    rsp_normal_z,
   output logic [hct_pkg::COLOR_W-1:0]         rsp_vertex_color,
   output logic                                rsp_last_vertex
);
   import hct_pkg::*;

   localparam int LAT = NRM_BASE_LAT + NORMAL_FRAC_BITS + 1;
   localparam int GRID_CMP_W = 18;

   typedef struct packed {
      logic [CELL_W-1:0]     cell_x;
      logic [CELL_W-1:0]     cell_z;
      logic [3:0][HGT_W-1:0] hgt;
      logic [COLOR_W-1:0]    color_first;
      logic [COLOR_W-1:0]    color_second;
   } item_type;

   logic [SCALE_W-1:0]    scale_x_ff, scale_z_ff, height_step_ff;
   logic [GRID_W-1:0]     grid_size_ff;
   logic                  color_enable_ff;
   logic [2:0]            gap_ff;
   logic                  phase_ff;
   item_type              hold_ff;
   item_type              dly_ff [0:LAT-1];
   logic [2:0][NRM_W-1:0] n0_ff, n0e_ff, n1e_ff;
   item_type              emit_ff;
   logic [2:0]            emit_k_ff;
   logic                  emit_act_ff;

   logic                  rsp_valid_ff, rsp_last_ff;
   logic [POS_W-1:0]      rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [NRM_W-1:0]      rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic [COLOR_W-1:0]    rsp_col_ff;

   logic                  accept;
   logic                  emit_load;
   item_type              req_item;
   job_type               job;
   nrm_out_type           nout;
   corner_type            crn;
   logic [GRID_W-1:0]     grid_in;
   logic [HGT_W-1:0]      hsel_val;
   logic [POS_W-1:0]      px_in, pz_in;

   function automatic logic [HGT_W:0] abs_diff(input logic [HGT_W-1:0] a,
                                               input logic [HGT_W-1:0] b);
      logic neg;
      neg = a < b;
      return {neg, neg ? HGT_W'(b - a) : HGT_W'(a - b)};
   endfunction

   function automatic logic [POS_W-1:0] grid_pos(input logic [CELL_W-1:0]  coord,
                                                 input logic               d,
                                                 input logic [GRID_W-1:0]  grid,
                                                 input logic [SCALE_W-1:0] scale);
      logic signed [GRID_W:0]           diff;
      logic signed [GRID_W+SCALE_W+1:0] prod;
      diff = $signed({1'b0, 13'({1'b0, coord} + 13'(d))}) -
             $signed({2'b00, 12'(grid >> 1)});
      prod = (GRID_W+SCALE_W+2)'(diff) * $signed({1'b0, scale});
      if (prod > $signed((GRID_W+SCALE_W+2)'(32'h7FFF_FFFF))) begin
         return 32'h7FFF_FFFF;
      end else if (prod < -$signed((GRID_W+SCALE_W+2)'(33'h0_8000_0000))) begin
         return 32'h8000_0000;
      end else begin
         return prod[POS_W-1:0];
      end
   endfunction

   assign accept    = start && !busy;
   assign busy      = (gap_ff != 3'd0);
   assign csr_ready = 1'b1;

   assign req_item = '{cell_x: req_cell_x, cell_z: req_cell_z,
                       hgt: {req_height_10, req_height_11, req_height_01, req_height_00},
                       color_first: req_color_first, color_second: req_color_second};

   always_comb begin
      logic [HGT_W:0] da, dc;
      if (accept) begin
         da = abs_diff(req_height_01, req_height_11);
         dc = abs_diff(req_height_00, req_height_01);
      end else begin
         da = abs_diff(hold_ff.hgt[HSEL_00], hold_ff.hgt[HSEL_10]);
         dc = abs_diff(hold_ff.hgt[HSEL_10], hold_ff.hgt[HSEL_11]);
      end
      job.valid  = accept || phase_ff;
      job.second = !accept;
      job.a_neg  = da[HGT_W];
      job.a_mag  = da[HGT_W-1:0];
      job.c_neg  = dc[HGT_W];
      job.c_mag  = dc[HGT_W-1:0];
   end

   hct_normal_pipe #(
      .FRAC_BITS(NORMAL_FRAC_BITS)
   ) u_nrm (
      .clock       (clock),
      .reset       (reset),
      .job         (job),
      .scale_x     (scale_x_ff),
      .scale_z     (scale_z_ff),
      .height_step (height_step_ff),
      .nout        (nout)
   );

   assign grid_in = (GRID_CMP_W'(csr_data[GRID_W-1:0]) > GRID_CMP_W'(MAX_GRID)) ?
                    GRID_W'(MAX_GRID) : csr_data[GRID_W-1:0];

   assign emit_load = nout.valid && nout.second;
   assign crn       = vertex_corner(emit_k_ff);
   assign hsel_val  = emit_ff.hgt[crn.hsel];
   assign px_in     = grid_pos(emit_ff.cell_x, crn.dx, grid_size_ff, scale_x_ff);
   assign pz_in     = grid_pos(emit_ff.cell_z, crn.dz, grid_size_ff, scale_z_ff);

   always_ff @(posedge clock) begin
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCALE_X:      scale_x_ff      <= csr_data;
            CSR_SCALE_Z:      scale_z_ff      <= csr_data;
            CSR_HEIGHT_STEP:  height_step_ff  <= csr_data;
            CSR_GRID_SIZE:    grid_size_ff    <= grid_in;
            CSR_COLOR_ENABLE: color_enable_ff <= csr_data[0];
            default: ;
         endcase
      end

      phase_ff <= accept;
      if (accept) begin
         gap_ff  <= 3'd5;
         hold_ff <= req_item;
      end else if (gap_ff != 3'd0) begin
         gap_ff <= gap_ff - 3'd1;
      end

      dly_ff[0] <= hold_ff;
      for (int i = 1; i < LAT; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end

      if (nout.valid && !nout.second) begin
         n0_ff <= nout.nrm;
      end

      rsp_valid_ff <= emit_act_ff;
      if (emit_act_ff) begin
         rsp_x_ff    <= px_in;
         rsp_y_ff    <= POS_W'(hsel_val) * POS_W'(height_step_ff);
         rsp_z_ff    <= pz_in;
         rsp_last_ff <= (emit_k_ff == 3'd5);
         if (emit_k_ff < 3'd3) begin
            {rsp_nz_ff, rsp_ny_ff, rsp_nx_ff} <= n0e_ff;
            rsp_col_ff <= color_enable_ff ? emit_ff.color_first : '0;
         end else begin
            {rsp_nz_ff, rsp_ny_ff, rsp_nx_ff} <= n1e_ff;
            rsp_col_ff <= color_enable_ff ? emit_ff.color_second : '0;
         end
      end
      if (emit_load) begin
         emit_ff     <= dly_ff[LAT-1];
         n0e_ff      <= n0_ff;
         n1e_ff      <= nout.nrm;
         emit_k_ff   <= 3'd0;
         emit_act_ff <= 1'b1;
      end else if (emit_act_ff) begin
         emit_k_ff   <= emit_k_ff + 3'd1;
         emit_act_ff <= (emit_k_ff != 3'd5);
      end

      if (reset) begin
         scale_x_ff      <= 24'd65536;
         scale_z_ff      <= 24'd65536;
         height_step_ff  <= 24'd256;
         grid_size_ff    <= 13'd256;
         color_enable_ff <= 1'b0;
         gap_ff          <= 3'd0;
         phase_ff        <= 1'b0;
         emit_act_ff     <= 1'b0;
         emit_k_ff       <= 3'd0;
         rsp_valid_ff    <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = rsp_x_ff;
   assign rsp_pos_y        = rsp_y_ff;
   assign rsp_pos_z        = rsp_z_ff;
   assign rsp_normal_x     = rsp_nx_ff;
   assign rsp_normal_y     = rsp_ny_ff;
   assign rsp_normal_z     = rsp_nz_ff;
   assign rsp_vertex_color = rsp_col_ff;
   assign rsp_last_vertex  = rsp_valid_ff && rsp_last_ff;

   // A new burst may only start when the previous one is on its last word.
   a_load_spacing: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> (!emit_act_ff || emit_k_ff == 3'd5))
      else $error("vertex burst overrun");

   // The second triangle of a cell always leaves the pipe in the cycle after the first.
   a_tri_pair: assert property (@(posedge clock) disable iff (reset)
      (nout.valid && nout.second) |-> $past(nout.valid && !nout.second))
      else $error("triangle jobs out of step");

   // Accepting a cell issues its second triangle next cycle and holds off start.
   a_accept_phase: assert property (@(posedge clock) disable iff (reset)
      accept |=> (phase_ff && busy))
      else $error("second triangle not issued");

   // The strobe of a last vertex comes only after five words of the same burst.
   a_last_after_five: assert property (@(posedge clock) disable iff (reset)
      rsp_last_vertex |-> $past(rsp_valid, 5))
      else $error("short vertex burst");

endmodule
